### sv/mwalu_pkg.sv
// Shared types and constants for the word-serial multi-precision ALU.
// No dependencies; used by multiword_alu_word_serial_top.
package mwalu_pkg;

   localparam int unsigned WordBits  = 64;
   localparam int unsigned ModeBits  = 4;
   localparam int unsigned WidthBits = 16;
   localparam int unsigned RemBits   = 6;

   typedef logic [WordBits-1:0]  word_type;
   typedef logic [ModeBits-1:0]  mode_type;
   typedef logic [1:0]           cmp_type;
   typedef logic [WidthBits-1:0] width_type;
   typedef logic [RemBits-1:0]   rem_type;

   // operation codes carried in req_tuser
   localparam mode_type MODE_ADD  = 4'd0;
   localparam mode_type MODE_SUB  = 4'd1;
   localparam mode_type MODE_AND  = 4'd2;
   localparam mode_type MODE_OR   = 4'd3;
   localparam mode_type MODE_XOR  = 4'd4;
   localparam mode_type MODE_NOT  = 4'd5;
   localparam mode_type MODE_NEG  = 4'd6;
   localparam mode_type MODE_UCMP = 4'd7;
   localparam mode_type MODE_SCMP = 4'd8;
   localparam mode_type MODE_NZ   = 4'd9;

   // compare verdict codes
   localparam cmp_type CMP_EQUAL   = 2'd0;
   localparam cmp_type CMP_LESS    = 2'd1;
   localparam cmp_type CMP_GREATER = 2'd2;

   localparam width_type WIDTH_RESET = 16'd128;

   // mask for the top word; a remainder of zero means a full word
   function automatic word_type top_mask(input rem_type rem);
      word_type m;
      begin
         m = (word_type'(1) << rem) - word_type'(1);
         if (rem == '0) begin
            m = '1;
         end
         return m;
      end
   endfunction

   // sign-extend a top word from the width, then flip bit 63 so that an
   // unsigned compare yields two's-complement order
   function automatic word_type signed_key(input word_type w, input rem_type rem);
      word_type low;
      word_type k;
      logic     sgn;
      begin
         low = top_mask(rem);
         sgn = w[rem - rem_type'(1)];
         k   = w;
         if (rem != '0) begin
            k = sgn ? (w | ~low) : (w & low);
         end
         k[WordBits-1] = ~k[WordBits-1];
         return k;
      end
   endfunction

endpackage

### sv/multiword_alu_word_serial_top.sv
// Word-serial ALU for wide integers: input register, combinational datapath,
// result register. Depends on mwalu_pkg.
//
// Usage:
//   req channel carries one 64-bit word pair of the operands per transfer,
//   least significant word first; req_tlast marks the top word and closes
//   the operand. req_tuser selects the operation for that word.
//   rsp channel returns one result word per request transfer, in order,
//   with rsp_tlast copied from req_tlast. Compare verdict and nonzero flag
//   ride on rsp_tuser and are final on the transfer with rsp_tlast set.
//   csr_wr_en / csr_wr_data write the operand width; only its low six bits
//   are used (top-word mask and sign position). Write it only while idle.
// Path: each req word passes the input register, then the result register,
//   before rsp_tvalid rises for it. Throughput: one word per cycle while
//   rsp_tready stays high, set by the combinational carry / compare update
//   between the two registers.
// Reset: both stages empty, carry clear, next word is an operand start,
//   width back to 128.
// Stall: while rsp_tready is low a full result register holds; an empty
//   input register still takes one more word, then req_tready drops.
module multiword_alu_word_serial_top (
   input  logic                             clock,
   input  logic                             reset,
   // slave side
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*mwalu_pkg::WordBits-1:0] req_tdata,  // {b_word, a_word}
   input  mwalu_pkg::mode_type              req_tuser,  // mode
   input  logic                             req_tlast,  // last_word
   // master side
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output mwalu_pkg::word_type              rsp_tdata,  // result_word
   output logic [2:0]                       rsp_tuser,  // {is_nonzero, compare_result}
   output logic                             rsp_tlast,  // last_out
   // configuration
   input  logic                             csr_wr_en,
   input  mwalu_pkg::width_type             csr_wr_data
);

   // input register
   logic                s1_valid_ff, s1_valid_in;
   mwalu_pkg::word_type s1_a_ff, s1_b_ff;
   mwalu_pkg::mode_type s1_mode_ff;
   logic                s1_last_ff;

   // result register
   logic                out_valid_ff, out_valid_in;
   mwalu_pkg::word_type out_data_ff, out_data_in;
   logic [2:0]          out_user_ff, out_user_in;
   logic                out_last_ff;

   // running state across the words of one operand
   logic                 carry_ff, carry_in;
   logic                 at_start_ff, at_start_in;
   mwalu_pkg::cmp_type   cmp_ff, cmp_in;
   logic                 nz_ff, nz_in;
   mwalu_pkg::width_type width_ff;

   logic s1_move;
   logic req_xfer;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   // datapath
   mwalu_pkg::rem_type  rem;
   mwalu_pkg::word_type mask;
   logic                carry_base;
   mwalu_pkg::cmp_type  cmp_base;
   logic                nz_base;
   logic [mwalu_pkg::WordBits:0] sum;
   mwalu_pkg::word_type cx, cy;
   mwalu_pkg::word_type res;
   logic                masked;
   mwalu_pkg::cmp_type  cmp_fold;

   always_comb begin
      rem  = width_ff[mwalu_pkg::RemBits-1:0];
      mask = mwalu_pkg::top_mask(rem);

      // first word of an operand restarts the running state
      carry_base = at_start_ff ? (s1_mode_ff == mwalu_pkg::MODE_NEG) : carry_ff;
      cmp_base   = at_start_ff ? mwalu_pkg::CMP_EQUAL : cmp_ff;
      nz_base    = at_start_ff ? 1'b0 : nz_ff;

      // compare operands: top word masked (unsigned) or keyed (signed)
      cx = s1_a_ff;
      cy = s1_b_ff;
      if (s1_last_ff) begin
         if (s1_mode_ff == mwalu_pkg::MODE_SCMP) begin
            cx = mwalu_pkg::signed_key(s1_a_ff, rem);
            cy = mwalu_pkg::signed_key(s1_b_ff, rem);
         end else begin
            cx = s1_a_ff & mask;
            cy = s1_b_ff & mask;
         end
      end
      cmp_fold = cmp_base;
      if (cx < cy) begin
         cmp_fold = mwalu_pkg::CMP_LESS;
      end else if (cx > cy) begin
         cmp_fold = mwalu_pkg::CMP_GREATER;
      end

      sum         = '0;
      res         = '0;
      masked      = 1'b0;
      carry_in    = carry_base;
      cmp_in      = cmp_base;
      nz_in       = nz_base;
      out_user_in = '0;

      unique case (s1_mode_ff)
         mwalu_pkg::MODE_ADD: begin
            sum = {1'b0, s1_a_ff} + {1'b0, s1_b_ff}
                  + {{mwalu_pkg::WordBits{1'b0}}, carry_base};
            res      = sum[mwalu_pkg::WordBits-1:0];
            carry_in = sum[mwalu_pkg::WordBits];
            masked   = 1'b1;
         end
         mwalu_pkg::MODE_SUB: begin
            // bit 64 of the difference is the borrow out
            sum = {1'b0, s1_a_ff} - {1'b0, s1_b_ff}
                  - {{mwalu_pkg::WordBits{1'b0}}, carry_base};
            res      = sum[mwalu_pkg::WordBits-1:0];
            carry_in = sum[mwalu_pkg::WordBits];
            masked   = 1'b1;
         end
         mwalu_pkg::MODE_AND: begin
            res = s1_a_ff & s1_b_ff; masked = 1'b1;
         end
         mwalu_pkg::MODE_OR: begin
            res = s1_a_ff | s1_b_ff; masked = 1'b1;
         end
         mwalu_pkg::MODE_XOR: begin
            res = s1_a_ff ^ s1_b_ff; masked = 1'b1;
         end
         mwalu_pkg::MODE_NOT: begin
            res = ~s1_a_ff; masked = 1'b1;
         end
         mwalu_pkg::MODE_NEG: begin
            sum = {1'b0, ~s1_a_ff} + {{mwalu_pkg::WordBits{1'b0}}, carry_base};
            res      = sum[mwalu_pkg::WordBits-1:0];
            carry_in = sum[mwalu_pkg::WordBits];
            masked   = 1'b1;
         end
         mwalu_pkg::MODE_UCMP, mwalu_pkg::MODE_SCMP: begin
            cmp_in      = cmp_fold;
            out_user_in = {1'b0, cmp_fold};
         end
         mwalu_pkg::MODE_NZ: begin
            nz_in       = nz_base || (s1_a_ff != '0);
            out_user_in = {nz_in, mwalu_pkg::CMP_EQUAL};
         end
         default: begin
            // undefined codes: zero result, state only restarts
         end
      endcase

      out_data_in = (masked && s1_last_ff) ? (res & mask) : res;
      at_start_in = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         carry_ff     <= 1'b0;
         at_start_ff  <= 1'b1;
         cmp_ff       <= mwalu_pkg::CMP_EQUAL;
         nz_ff        <= 1'b0;
         width_ff     <= mwalu_pkg::WIDTH_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         if (s1_move) begin
            carry_ff    <= carry_in;
            at_start_ff <= at_start_in;
            cmp_ff      <= cmp_in;
            nz_ff       <= nz_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_a_ff    <= req_tdata[mwalu_pkg::WordBits-1:0];
         s1_b_ff    <= req_tdata[2*mwalu_pkg::WordBits-1:mwalu_pkg::WordBits];
         s1_mode_ff <= req_tuser;
         s1_last_ff <= req_tlast;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   // a verdict or flag comes only with a zero result word
   a_flags_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 3'b000) |-> rsp_tdata == '0)
      else $error("flag set with nonzero result word");

   // compare verdict and nonzero flag never on the same word
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == mwalu_pkg::CMP_EQUAL)
      else $error("compare and nonzero both reported");

   // a word leaving with the top-word mark restarts the next operand
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_last_ff |=> at_start_ff)
      else $error("operand start not armed after top word");

   // an input word is never dropped while the result side stalls
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_a_ff))
      else $error("input stage lost a word during stall");

endmodule
